FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication between a condition and a consequence in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   `ASSERT_CLK(label, clk, rst, (ante) |=> (cons))

// Implication between a condition and a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons))

`endif

FILE: rtl/vdht_pkg.sv
package vdht_pkg;

   localparam int TABLE_SIZE_DEFAULT = 4096;

   localparam int COORD_W    = 16;
   localparam int COLOUR_W   = 8;
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 1;

   localparam logic [31:0] SEED_KEY  = 32'd5381;
   localparam logic [31:0] BASE_FRAC = 32'd2654435766;
   localparam logic [31:0] STEP_FRAC = 32'd3037000499;

   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_PRESENT   = 3'd1,
      STATUS_FOUND     = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_Z
   } coord_sel_type;

   typedef struct packed {
      logic          load;
      logic          hash_en;
      coord_sel_type hash_sel;
      logic          key_en;
      logic          mul_en;
      logic          mul_step;
      logic          set_start;
      logic          set_step;
      logic          rd_en;
      logic          advance;
      logic          clear_en;
      logic          finish;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic resolved;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/vdht_ctrl.sv
module vdht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  vdht_pkg::stat_type stat,
   output vdht_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_X,
      ST_HASH_Y,
      ST_HASH_Z,
      ST_KEY,
      ST_MUL_BASE,
      ST_MUL_STEP,
      ST_FIRST,
      ST_CHECK,
      ST_READ
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.hash_sel = vdht_pkg::SEL_X;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH_X;
            end
         end
         ST_HASH_X: begin
            cmd.hash_en  = 1'b1;
            cmd.hash_sel = vdht_pkg::SEL_X;
            state_in     = ST_HASH_Y;
         end
         ST_HASH_Y: begin
            cmd.hash_en  = 1'b1;
            cmd.hash_sel = vdht_pkg::SEL_Y;
            state_in     = ST_HASH_Z;
         end
         ST_HASH_Z: begin
            cmd.hash_en  = 1'b1;
            cmd.hash_sel = vdht_pkg::SEL_Z;
            state_in     = ST_KEY;
         end
         ST_KEY: begin
            cmd.key_en = 1'b1;
            state_in   = ST_MUL_BASE;
         end
         ST_MUL_BASE: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_MUL_STEP;
         end
         ST_MUL_STEP: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_step  = 1'b1;
            cmd.set_start = 1'b1;
            state_in      = ST_FIRST;
         end
         ST_FIRST: begin
            cmd.set_step = 1'b1;
            cmd.rd_en    = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.resolved) begin
               if (stat.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/vdht_datapath.sv
module vdht_datapath #(
   parameter  int TABLE_SIZE = vdht_pkg::TABLE_SIZE_DEFAULT,
   localparam int SLOT_W     = $clog2(TABLE_SIZE),
   localparam int RSP_W      = ((2 * SLOT_W + 4 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  vdht_pkg::cmd_type                cmd,
   output vdht_pkg::stat_type               stat,
   input  logic [vdht_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [vdht_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_W-1:0]                 rsp_tdata
);

   localparam int CW  = vdht_pkg::COORD_W;
   localparam int KW  = 3 * vdht_pkg::COORD_W;
   localparam int CLW = 3 * vdht_pkg::COLOUR_W;

   typedef struct packed {
      logic           valid;
      logic [KW-1:0]  coords;
      logic [CLW-1:0] colour;
   } entry_type;

   entry_type mem [TABLE_SIZE];
   entry_type rd_ff;

   logic [KW-1:0]     coords_ff;
   logic [CLW-1:0]    colour_ff;
   logic              find_ff;
   logic [31:0]       h_ff, h_in;
   logic [31:0]       key_ff, key_in;
   logic [31:0]       frac_ff, frac_in;
   logic [31:0]       mul_const;
   logic [CW-1:0]     coord_sel;
   logic [31:0]       coord_ext;
   logic [SLOT_W-1:0] addr_ff, step_ff, probes_ff, clr_ff;
   logic [SLOT_W:0]   count_ff, count_in;
   logic              rsp_valid_ff;
   vdht_pkg::status_type status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W:0]   occ_ff;
   logic              hit_empty, hit_match, do_insert;

   always_comb begin
      case (cmd.hash_sel)
         vdht_pkg::SEL_X: coord_sel = coords_ff[CW-1:0];
         vdht_pkg::SEL_Y: coord_sel = coords_ff[2*CW-1:CW];
         vdht_pkg::SEL_Z: coord_sel = coords_ff[3*CW-1:2*CW];
         default:         coord_sel = '0;
      endcase
   end

   assign coord_ext = {{(32 - CW){coord_sel[CW-1]}}, coord_sel};
   assign h_in      = {h_ff[26:0], 5'b0} + h_ff + coord_ext;
   assign key_in    = h_ff[31] ? (~h_ff + 32'd1) : h_ff;
   assign mul_const = cmd.mul_step ? vdht_pkg::STEP_FRAC : vdht_pkg::BASE_FRAC;
   assign frac_in   = key_ff * mul_const;

   assign hit_empty = !rd_ff.valid;
   assign hit_match = rd_ff.valid && (rd_ff.coords == coords_ff);
   assign do_insert = hit_empty && !find_ff;
   assign count_in  = count_ff + (SLOT_W + 1)'(do_insert);

   always_comb begin
      if (hit_empty) begin
         status_in = find_ff ? vdht_pkg::STATUS_NOT_FOUND : vdht_pkg::STATUS_INSERTED;
         slot_in   = find_ff ? '0 : addr_ff;
      end else if (hit_match) begin
         status_in = find_ff ? vdht_pkg::STATUS_FOUND : vdht_pkg::STATUS_PRESENT;
         slot_in   = addr_ff;
      end else begin
         status_in = find_ff ? vdht_pkg::STATUS_NOT_FOUND : vdht_pkg::STATUS_FULL;
         slot_in   = '0;
      end
   end

   assign stat.clr_last = (clr_ff == '1);
   assign stat.resolved = hit_empty || hit_match || (probes_ff == '1);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         coords_ff <= req_tdata[KW-1:0];
         colour_ff <= {req_tdata[KW+7:KW], req_tdata[KW+15:KW+8], req_tdata[KW+23:KW+16]};
         find_ff   <= req_tuser[0];
         h_ff      <= vdht_pkg::SEED_KEY;
      end else if (cmd.hash_en) begin
         h_ff <= h_in;
      end
      if (cmd.key_en) begin
         key_ff <= key_in;
      end
      if (cmd.mul_en) begin
         frac_ff <= frac_in;
      end
      if (cmd.set_start) begin
         addr_ff   <= frac_ff[31 -: SLOT_W];
         probes_ff <= '0;
      end else if (cmd.advance) begin
         addr_ff   <= addr_ff + step_ff;
         probes_ff <= probes_ff + SLOT_W'(1);
      end
      if (cmd.set_step) begin
         step_ff <= frac_ff[31 -: SLOT_W] | SLOT_W'(1);
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         occ_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         mem[clr_ff] <= '0;
      end else if (cmd.finish && do_insert) begin
         mem[addr_ff] <= {1'b1, coords_ff, colour_ff};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + SLOT_W'(1);
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({occ_ff, slot_ff, status_ff});

endmodule

FILE: rtl/voxel_double_hash_table_top.sv
// An accepted request passes HASH_X, HASH_Y, HASH_Z, KEY, MUL_BASE, MUL_STEP, FIRST and
// CHECK, plus READ and CHECK for every probe beyond the first; each probe is one table read
// and one compare. No new request is taken until CHECK finishes, which waits while the last
// response is not yet taken. Reset is synchronous and active high; afterwards a clearing
// pass over the table runs, during which no request is taken.
`include "assert_macros.svh"

module voxel_double_hash_table_top #(
   parameter  int TABLE_SIZE = vdht_pkg::TABLE_SIZE_DEFAULT,
   localparam int SLOT_W     = $clog2(TABLE_SIZE),
   localparam int RSP_W      = ((2 * SLOT_W + 4 + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // voxel_x, voxel_y, voxel_z, red, green, blue
   input  logic [vdht_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [vdht_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, slot, occupied, zero padding
   output logic [RSP_W-1:0]                rsp_tdata
);

   vdht_pkg::cmd_type  cmd;
   vdht_pkg::stat_type stat;

   vdht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vdht_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_NEXT(a_finish_gives_response, clock, reset, cmd.finish, rsp_tvalid)
   `ASSERT_SAME(a_no_accept_while_clearing, clock, reset, cmd.clear_en, !req_tready)

endmodule
